// ----- rtl/sclc_pkg.sv -----
package sclc_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned SECTOR_BYTES_DEF = 512;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Classified transaction passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sector;
    logic        partial;
  } sclc_cmd_t;

endpackage

// ----- rtl/sclc_front.sv -----
module sclc_front #(
  parameter int unsigned SECTOR_BYTES = sclc_pkg::SECTOR_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [31:0]         in_request_sector,
  input  logic [8:0]          in_write_offset,
  input  logic [9:0]          in_write_size,
  output logic                q_valid,
  input  logic                q_pop,
  output sclc_pkg::sclc_cmd_t q_cmd
);
  import sclc_pkg::*;

  localparam logic [12:0] SECT_BYTES = 13'(SECTOR_BYTES);

  sclc_cmd_t  q_mem_r [2];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       push;
  sclc_cmd_t  cmd;

  // Classify: code 3 is dropped here, partial writes flagged.
  always_comb begin
    cmd.op      = in_operation;
    cmd.sector  = in_request_sector;
    cmd.partial = (in_write_offset != 9'd0) || ({3'd0, in_write_size} < SECT_BYTES);
  end

  assign in_stall = (q_cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && (in_operation != OP_NONE);
  assign q_valid  = (q_cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (push && !q_pop) begin
      q_cnt_nxt = q_cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  // Two-entry queue between classifier and executor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r == 2'd2 |-> !push || q_pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_cnt_r != 2'd0) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3) else $error("queue count out of range");

endmodule

// ----- rtl/sclc_back.sv -----
module sclc_back #(
  parameter int unsigned SLOTS = sclc_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  sclc_pkg::sclc_cmd_t q_cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          out_slot,
  output logic                out_hit,
  output logic                out_writeback_valid,
  output logic [31:0]         out_writeback_sector,
  output logic                out_fill_from_disk,
  output logic                out_write_through,
  output logic [31:0]         out_hit_count,
  output logic                out_last
);
  import sclc_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW:0] SLOTS_W = (SW + 1)'(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_FLUSH, S_OUT} state_t;

  state_t          state_r;
  logic [31:0]     tag_r   [SLOTS];
  logic [SLOTS-1:0] valid_r, dirty_r;
  logic [SW-1:0]   order_r [SLOTS];
  logic [31:0]     hits_r;
  sclc_cmd_t       cmd_r;
  logic [SW:0]     fpos_r;
  logic            fany_r;

  // Each slot compares its own tag against the request.
  logic [SLOTS-1:0] slot_match;
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_match[s] = valid_r[s] && (tag_r[s] == cmd_r.sector);
    end
  end

  // Per-position view of the recency list.
  logic [SLOTS-1:0] pos_match, pos_free, pos_dirty;
  always_comb begin
    for (int p = 0; p < SLOTS; p++) begin
      pos_match[p] = slot_match[order_r[p]];
      pos_free[p]  = !valid_r[order_r[p]];
      pos_dirty[p] = valid_r[order_r[p]] && dirty_r[order_r[p]];
    end
  end

  // Priority picks in recency order.
  logic [SW-1:0] hit_pos, free_pos, victim_pos, flush_pos;
  logic          any_hit, any_free, any_dirty_rest;
  always_comb begin
    hit_pos = '0; free_pos = '0; any_hit = 1'b0; any_free = 1'b0;
    flush_pos = '0; any_dirty_rest = 1'b0;
    for (int p = SLOTS - 1; p >= 0; p--) begin
      if (pos_match[p]) begin
        hit_pos = SW'(p); any_hit = 1'b1;
      end
      if (pos_free[p]) begin
        free_pos = SW'(p); any_free = 1'b1;
      end
      if (pos_dirty[p] && ((SW + 1)'(p) >= fpos_r)) begin
        flush_pos = SW'(p); any_dirty_rest = 1'b1;
      end
    end
  end

  always_comb begin
    if (any_hit) victim_pos = hit_pos;
    else if (any_free) victim_pos = free_pos;
    else victim_pos = SW'(SLOTS - 1);
  end

  // Is there another dirty slot after the one being flushed now?
  logic more_dirty;
  always_comb begin
    more_dirty = 1'b0;
    for (int p = 0; p < SLOTS; p++) begin
      if (pos_dirty[p] && (SW'(p) > flush_pos)) more_dirty = 1'b1;
    end
  end

  logic [SW-1:0] vslot;
  assign vslot = order_r[victim_pos];
  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      dirty_r   <= '0;
      hits_r    <= '0;
      out_valid <= 1'b0;
      fpos_r    <= '0;
      fany_r    <= 1'b0;
      for (int p = 0; p < SLOTS; p++) order_r[p] <= SW'(p);
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r  <= q_cmd;
            fpos_r <= '0;
            fany_r <= 1'b0;
            state_r <= (q_cmd.op == OP_FLUSH) ? S_FLUSH : S_LOOK;
          end
        end
        // Look up, update the slot and recency list, present the result.
        S_LOOK: begin
          for (int p = 1; p < SLOTS; p++) begin
            if (SW'(p) <= victim_pos) order_r[p] <= order_r[p - 1];
          end
          order_r[0] <= vslot;
          out_slot             <= 6'(vslot);
          out_hit              <= any_hit;
          out_writeback_valid  <= 1'b0;
          out_writeback_sector <= '0;
          out_fill_from_disk   <= 1'b0;
          out_write_through    <= 1'b0;
          out_last             <= 1'b1;
          if (any_hit && (cmd_r.op == OP_READ)) begin
            out_hit_count <= hits_r + 32'd1;
          end else begin
            out_hit_count <= hits_r;
          end
          if (any_hit) begin
            if (cmd_r.op == OP_READ) begin
              hits_r <= hits_r + 32'd1;
            end else begin
              dirty_r[vslot] <= 1'b1;
            end
          end else begin
            if (!any_free && dirty_r[vslot]) begin
              out_writeback_valid  <= 1'b1;
              out_writeback_sector <= tag_r[vslot];
            end
            tag_r[vslot]   <= cmd_r.sector;
            valid_r[vslot] <= 1'b1;
            dirty_r[vslot] <= 1'b0;
            out_fill_from_disk <= (cmd_r.op == OP_READ) || cmd_r.partial;
            out_write_through  <= (cmd_r.op == OP_WRITE);
          end
          out_valid <= 1'b1;
          state_r   <= S_OUT;
        end
        // Emit one writeback per dirty slot in recency order, or one empty result.
        S_FLUSH: begin
          hits_r               <= '0;
          out_hit              <= 1'b0;
          out_fill_from_disk   <= 1'b0;
          out_write_through    <= 1'b0;
          out_hit_count        <= '0;
          if (any_dirty_rest) begin
            out_slot             <= 6'(order_r[flush_pos]);
            out_writeback_valid  <= 1'b1;
            out_writeback_sector <= tag_r[order_r[flush_pos]];
            out_last             <= !more_dirty;
            fpos_r               <= {1'b0, flush_pos} + (SW + 1)'(1);
            fany_r               <= 1'b1;
          end else begin
            out_slot             <= '0;
            out_writeback_valid  <= 1'b0;
            out_writeback_sector <= '0;
            out_last             <= 1'b1;
          end
          if (!any_dirty_rest || !more_dirty) begin
            valid_r <= '0;
            dirty_r <= '0;
          end
          out_valid <= 1'b1;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_last) state_r <= S_IDLE;
            else state_r <= S_FLUSH;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output state");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_LOOK || state_r == S_FLUSH) else $error("pop lost");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_hit && out_hit_count == 32'd0 && !out_fill_from_disk
    && !out_write_through && fany_r |-> dirty_r == '0) else $error("flush left dirty");
  a_fpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fpos_r <= SLOTS_W) else $error("flush position out of range");

endmodule

// ----- rtl/sector_cache_lru_controller_unit.sv -----
// Tag, valid, dirty and LRU controller for a fully associative sector cache.
// Input channel (in_*): one transaction per read, write or flush request;
// operation code 3 is accepted and dropped without a result.
// Result channel (out_*): one transaction per read or write; a flush gives
// one transaction per dirty slot in recency order, or one empty result.
// out_last marks the final result of a request.
// A front end classifies requests into a two-entry queue; the back end does
// a parallel tag compare and priority pick, then shifts the recency list.
// With an idle back end, an accepted read or write passes through the queue,
// the back end's pop into lookup and the registered output before it shows.
// The back end handles one request at a time: a read or write takes its pop,
// lookup and output steps; a flush takes its pop, then a flush and output
// step per result. Stalls lengthen the output step.
// Reset empties the cache, restores recency order 0..SLOTS-1 and zeroes the
// hit count. A stall on out_* holds the result; the queue keeps accepting
// until its two entries are full, then in_stall rises.
module sector_cache_lru_controller_unit #(
  parameter int unsigned SLOTS        = sclc_pkg::SLOTS_DEF,
  parameter int unsigned SECTOR_BYTES = sclc_pkg::SECTOR_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_request_sector,
  input  logic [8:0]  in_write_offset,
  input  logic [9:0]  in_write_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_slot,
  output logic        out_hit,
  output logic        out_writeback_valid,
  output logic [31:0] out_writeback_sector,
  output logic        out_fill_from_disk,
  output logic        out_write_through,
  output logic [31:0] out_hit_count,
  output logic        out_last
);
  import sclc_pkg::*;

  logic      q_valid, q_pop;
  sclc_cmd_t q_cmd;

  sclc_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_request_sector,
    .in_write_offset, .in_write_size, .q_valid, .q_pop, .q_cmd
  );

  sclc_back #(.SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_stall, .out_slot,
    .out_hit, .out_writeback_valid, .out_writeback_sector, .out_fill_from_disk,
    .out_write_through, .out_hit_count, .out_last
  );

endmodule

// ----- tb/sv/sector_cache_lru_checker.sv -----
`timescale 1ns / 1ps

module sector_cache_lru_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_request_sector,
  input  logic [8:0]  in_write_offset,
  input  logic [9:0]  in_write_size,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_slot,
  input  logic        out_hit,
  input  logic        out_writeback_valid,
  input  logic [31:0] out_writeback_sector,
  input  logic        out_fill_from_disk,
  input  logic        out_write_through,
  input  logic [31:0] out_hit_count,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);
  import sclc_pkg::*;

  localparam int NSLOT = 64;
  localparam int SECTOR_SIZE = 512;

  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        wb_valid;
    logic [31:0] wb_sector;
    logic        fill;
    logic        wthru;
    logic [31:0] hits;
    logic        last;
  } cache_resp_t;

  // Shadow copy of the cache directory.
  logic [31:0] shadow_tag [NSLOT];
  logic        shadow_valid [NSLOT];
  logic        shadow_dirty [NSLOT];
  logic [5:0]  shadow_order [NSLOT];
  logic [31:0] shadow_hits;
  cache_resp_t expected_resps [$];

  assign pending_count = expected_resps.size();

  // Moves the slot at recency position pos to the front and returns it.
  function automatic logic [5:0] promote(int pos);
    logic [5:0] s;
    s = shadow_order[pos];
    for (int i = pos; i > 0; i--) shadow_order[i] = shadow_order[i - 1];
    shadow_order[0] = s;
    return s;
  endfunction

  task automatic predict_access(logic [1:0] op, logic [31:0] sector,
                                logic [8:0] offset, logic [9:0] size);
    cache_resp_t r;
    logic [5:0] s;
    int free_pos;
    int n;
    free_pos = -1;
    n = 0;
    r = '0;
    if (op == OP_NONE) return;
    if (op == OP_FLUSH) begin
      shadow_hits = 0;
      for (int p = 0; p < NSLOT; p++) begin
        s = shadow_order[p];
        if (shadow_valid[s] && shadow_dirty[s]) begin
          r = '0;
          r.slot = s;
          r.wb_valid = 1'b1;
          r.wb_sector = shadow_tag[s];
          expected_resps.push_back(r);
          n++;
        end
      end
      for (int i = 0; i < NSLOT; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_dirty[i] = 1'b0;
      end
      if (n == 0) begin
        r = '0;
        r.last = 1'b1;
        expected_resps.push_back(r);
      end else begin
        expected_resps[$].last = 1'b1;
      end
      return;
    end
    // Lookup across all slots in recency order.
    for (int p = 0; p < NSLOT; p++) begin
      s = shadow_order[p];
      if (shadow_valid[s]) begin
        if (shadow_tag[s] == sector) begin
          void'(promote(p));
          if (op == OP_READ) shadow_hits++;
          else shadow_dirty[s] = 1'b1;
          r.slot = s;
          r.hit = 1'b1;
          r.hits = shadow_hits;
          r.last = 1'b1;
          expected_resps.push_back(r);
          return;
        end
      end else if (free_pos < 0) begin
        free_pos = p;
      end
    end
    // Miss: take a free slot or evict the least recent one.
    if (free_pos >= 0) begin
      s = promote(free_pos);
    end else begin
      s = promote(NSLOT - 1);
      if (shadow_dirty[s]) begin
        r.wb_valid = 1'b1;
        r.wb_sector = shadow_tag[s];
      end
    end
    shadow_tag[s] = sector;
    shadow_valid[s] = 1'b1;
    shadow_dirty[s] = 1'b0;
    r.slot = s;
    r.hits = shadow_hits;
    r.last = 1'b1;
    if (op == OP_READ) begin
      r.fill = 1'b1;
    end else begin
      r.fill = (offset != 0) || (size < SECTOR_SIZE);
      r.wthru = 1'b1;
    end
    expected_resps.push_back(r);
  endtask

  initial begin
    shadow_hits = 0;
    for (int i = 0; i < NSLOT; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_order[i] = i[5:0];
    end
  end

  // Predict on each accepted request transaction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      predict_access(in_operation, in_request_sector, in_write_offset, in_write_size);
  end

  // Compare each accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    cache_resp_t got;
    cache_resp_t want;
    if (!rst_n) begin
      fail_count = 0;
    end else if (out_valid && !out_stall) begin
      got = '{out_slot, out_hit, out_writeback_valid, out_writeback_sector,
              out_fill_from_disk, out_write_through, out_hit_count, out_last};
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        fail_count++;
      end else begin
        want = expected_resps.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
          fail_count++;
        end
      end
    end
  end
endmodule

// ----- tb/sv/sector_cache_lru_controller_unit_tb.sv -----
`timescale 1ns / 1ps

module sector_cache_lru_controller_unit_tb;
  import sclc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [31:0] in_request_sector;
  logic [8:0]  in_write_offset;
  logic [9:0]  in_write_size;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_slot;
  logic        out_hit;
  logic        out_writeback_valid;
  logic [31:0] out_writeback_sector;
  logic        out_fill_from_disk;
  logic        out_write_through;
  logic [31:0] out_hit_count;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  bit          quiet_tail;
  bit          hold_results;
  logic [31:0] sector_pool [8];

  sector_cache_lru_controller_unit dut (.*);
  sector_cache_lru_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Send one request transaction, with an occasional idle burst before it.
  task automatic send_request(logic [1:0] op, logic [31:0] sector,
                              logic [8:0] offset, logic [9:0] size);
    int gap;
    gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_sector <= sector;
    in_write_offset <= offset;
    in_write_size <= size;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random access that often reuses a small working set to make hits.
  task automatic random_request();
    logic [1:0] op;
    logic [31:0] sector;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_READ;
    else if (pick < 90) op = OP_WRITE;
    else if (pick < 95) op = OP_FLUSH;
    else op = OP_NONE;
    if ($urandom_range(0, 9) < 3) sector = sector_pool[$urandom_range(0, 7)];
    else if ($urandom_range(0, 1)) sector = $urandom_range(0, 90);
    else sector = $urandom;
    send_request(op, sector, ($urandom_range(0, 1)) ? 9'd0 : 9'($urandom),
                 ($urandom_range(0, 1)) ? 10'd512 : 10'($urandom_range(0, 1023)));
  endtask

  // Result-side stall: random bursts, one long hold, none in the tail.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int tail_wait;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_READ;
    in_request_sector = '0;
    in_write_offset = '0;
    in_write_size = '0;
    quiet_tail = 1'b0;
    hold_results = 1'b0;
    for (int i = 0; i < 8; i++) sector_pool[i] = $urandom;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: misses, hits, partial and full writes, ignored code, flushes.
    send_request(OP_FLUSH, 32'd0, 9'd0, 10'd0);
    send_request(OP_READ, 32'hFFFF_FFFF, 9'd0, 10'd0);
    send_request(OP_READ, 32'hFFFF_FFFF, 9'd0, 10'd0);
    send_request(OP_WRITE, 32'hFFFF_FFFF, 9'd511, 10'd1023);
    send_request(OP_WRITE, 32'd0, 9'd0, 10'd512);
    send_request(OP_WRITE, 32'd1, 9'd0, 10'd511);
    send_request(OP_WRITE, 32'd2, 9'd511, 10'd0);
    send_request(OP_WRITE, 32'd3, 9'd0, 10'd1023);
    send_request(OP_WRITE, 32'd0, 9'h155, 10'h2AA);
    send_request(OP_NONE, 32'hA5A5_5A5A, 9'h1FF, 10'h3FF);
    send_request(OP_READ, 32'd1, 9'd0, 10'd0);
    send_request(OP_FLUSH, 32'd0, 9'd0, 10'd0);
    send_request(OP_READ, 32'd0, 9'd0, 10'd0);
    // Fill every slot, dirty them, then evict dirty slots.
    for (int i = 0; i < 64; i++) send_request(OP_WRITE, 32'h100 + i, 9'd0, 10'd512);
    for (int i = 0; i < 64; i++) send_request(OP_WRITE, 32'h100 + i, 9'd0, 10'd512);
    for (int i = 0; i < 4; i++) send_request(OP_READ, 32'h200 + i, 9'd0, 10'd0);
    // Long receiver hold while requests keep coming, so the input backs up.
    fork
      begin
        hold_results = 1'b1;
        repeat (40) @(negedge clk);
        hold_results = 1'b0;
      end
      for (int i = 0; i < 10; i++) random_request();
    join
    send_request(OP_FLUSH, 32'd0, 9'd0, 10'd0);

    for (int i = 0; i < 150; i++) begin
      if (i == 120) quiet_tail = 1'b1;
      random_request();
    end
    in_valid <= 1'b0;

    tail_wait = 0;
    while (pending_count != 0 && tail_wait < 100000) begin
      @(negedge clk);
      tail_wait++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/sclc_pkg.sv
rtl/sclc_front.sv
rtl/sclc_back.sv
rtl/sector_cache_lru_controller_unit.sv
tb/sv/sector_cache_lru_checker.sv
tb/sv/sector_cache_lru_controller_unit_tb.sv
